// File: hdl/nearest_weight_vector_search_unit_defines.svh
// assertion macros shared by the search unit
`ifndef NEAREST_WEIGHT_VECTOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_WEIGHT_VECTOR_SEARCH_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define NWVS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the next cycle
`define NWVS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/nwvs_pkg.sv
// types and constants of the nearest weight vector search unit
package nwvs_pkg;

   localparam int VALUE_WIDTH    = 16;
   localparam int NIDX_FIELD_W   = 10;
   localparam int DIDX_FIELD_W   = 6;
   localparam int OUT_W          = 11;
   localparam int NCOUNT_REG_W   = 11;
   localparam int DCOUNT_REG_W   = 7;
   localparam int COLS_REG_W     = 11;
   localparam int CSR_DATA_W     = 11;
   localparam int CSR_INDEX_W    = 2;

   localparam logic CMD_LOAD_WEIGHT = 1'b0;
   localparam logic CMD_DATA_POINT  = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEURON_COUNT    = 2'd0,
      CSR_DIMENSION_COUNT = 2'd1,
      CSR_GRID_COLUMNS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                           cmd;
      logic [NIDX_FIELD_W-1:0]        neuron_index;
      logic [DIDX_FIELD_W-1:0]        dim_index;
      logic signed [VALUE_WIDTH-1:0]  value;
      logic                           last;
   } nwvs_req_type;

   typedef struct packed {
      logic [OUT_W-1:0] bmu_row;
      logic [OUT_W-1:0] bmu_col;
   } nwvs_rsp_type;

   typedef struct packed {
      logic wr_weight;
      logic wr_point;
      logic mac_valid;
      logic first_dim;
      logic last_dim;
      logic first_neuron;
      logic div_start;
   } nwvs_cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic div_done;
   } nwvs_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_DIVIDE
   } nwvs_state_type;

endpackage

// File: hdl/nwvs_ctrl.sv
// controller: item intake and neuron/dimension sweep sequencing
module nwvs_ctrl #(
   parameter int NIDX_W = 10,
   parameter int DIDX_W = 6,
   parameter int NCNT_W = 11,
   parameter int DCNT_W = 7
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic                     req_last,
   input  logic [NCNT_W-1:0]        neuron_limit,
   input  logic [DCNT_W-1:0]        dim_limit,
   output nwvs_pkg::nwvs_cmd_type   dp_cmd,
   output logic [NIDX_W-1:0]        mac_nidx,
   output logic [DIDX_W-1:0]        mac_didx,
   input  nwvs_pkg::nwvs_status_type dp_status
);
   import nwvs_pkg::*;

   nwvs_state_type    state_ff, state_in;
   logic [NIDX_W-1:0] nidx_ff, nidx_in;
   logic [DIDX_W-1:0] didx_ff, didx_in;
   logic              last_dim, last_neuron;

   assign last_dim    = (DCNT_W'(didx_ff) + DCNT_W'(1)) == dim_limit;
   assign last_neuron = (NCNT_W'(nidx_ff) + NCNT_W'(1)) == neuron_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nidx_ff  <= '0;
         didx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         nidx_ff  <= nidx_in;
         didx_ff  <= didx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      nidx_in  = nidx_ff;
      didx_in  = didx_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_DATA_POINT) begin
                  dp_cmd.wr_point = 1'b1;
                  if (req_last) begin
                     state_in = ST_SWEEP;
                     nidx_in  = '0;
                     didx_in  = '0;
                  end
               end else begin
                  dp_cmd.wr_weight = 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            dp_cmd.mac_valid    = 1'b1;
            dp_cmd.first_dim    = (didx_ff == '0);
            dp_cmd.last_dim     = last_dim;
            dp_cmd.first_neuron = (nidx_ff == '0);
            if (last_dim) begin
               didx_in = '0;
               if (last_neuron) begin
                  state_in = ST_DRAIN;
               end else begin
                  nidx_in = NIDX_W'(nidx_ff + 1'b1);
               end
            end else begin
               didx_in = DIDX_W'(didx_ff + 1'b1);
            end
         end
         ST_DRAIN: begin
            if (!dp_status.pipe_busy) begin
               dp_cmd.div_start = 1'b1;
               state_in         = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (dp_status.div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy     = (state_ff != ST_IDLE);
   assign mac_nidx = nidx_ff;
   assign mac_didx = didx_ff;

endmodule

// File: hdl/nwvs_divider.sv
// restoring divider: neuron index into grid row and column, one bit a cycle
module nwvs_divider #(
   parameter int DIVIDEND_W = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [DIVIDEND_W-1:0]           dividend,
   input  logic [nwvs_pkg::COLS_REG_W-1:0] divisor,
   output logic                            done,
   output logic [DIVIDEND_W-1:0]           quotient,
   output logic [nwvs_pkg::COLS_REG_W-1:0] remainder
);
   import nwvs_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  run_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] quo_ff;
   logic [COLS_REG_W-1:0] rem_ff;
   logic [COLS_REG_W-1:0] div_ff;
   logic [COLS_REG_W:0]   trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= run_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= CNT_W'(DIVIDEND_W);
         end else if (run_ff) begin
            cnt_ff <= CNT_W'(cnt_ff - 1'b1);
            if (cnt_ff == CNT_W'(1)) begin
               run_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (run_ff) begin
         quo_ff <= DIVIDEND_W'({quo_ff, fits});
         rem_ff <= fits ? COLS_REG_W'(trial - {1'b0, div_ff}) : COLS_REG_W'(trial);
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: hdl/nwvs_datapath.sv
// datapath: weight and point memories, distance pipeline, best tracking
module nwvs_datapath #(
   parameter int MAX_NEURONS = 1024,
   parameter int MAX_DIMS    = 64,
   parameter int NIDX_W      = 10,
   parameter int DIDX_W      = 6
) (
   input  logic                            clock,
   input  logic                            reset,
   input  nwvs_pkg::nwvs_cmd_type          dp_cmd,
   input  logic [NIDX_W-1:0]               mac_nidx,
   input  logic [DIDX_W-1:0]               mac_didx,
   input  nwvs_pkg::nwvs_req_type          req_data,
   input  logic [nwvs_pkg::COLS_REG_W-1:0] cols_limit,
   output nwvs_pkg::nwvs_status_type       dp_status,
   output logic                            rsp_valid,
   output nwvs_pkg::nwvs_rsp_type          rsp_data
);
   import nwvs_pkg::*;

   localparam int WDEPTH  = MAX_NEURONS * MAX_DIMS;
   localparam int ADDR_W  = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int SQ_W    = 2 * VALUE_WIDTH + 1;
   localparam int DIST_W  = SQ_W + $clog2(MAX_DIMS) + 1;
   localparam logic [ADDR_W-1:0] DIM_STRIDE = ADDR_W'(MAX_DIMS);

   logic [VALUE_WIDTH-1:0] weight_mem [WDEPTH];
   logic [VALUE_WIDTH-1:0] point_mem  [MAX_DIMS];

   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic              wr_weight_ok, wr_point_ok;

   // tags traveling with each multiply-accumulate
   logic              v1_ff, v2_ff, v3_ff;
   logic              fd1_ff, fd2_ff, fd3_ff;
   logic              ld1_ff, ld2_ff, ld3_ff;
   logic              fn1_ff, fn2_ff, fn3_ff, fn4_ff;
   logic [NIDX_W-1:0] ix1_ff, ix2_ff, ix3_ff, ix4_ff;

   logic signed [VALUE_WIDTH-1:0] w_rd_ff, p_rd_ff;
   logic signed [VALUE_WIDTH:0]   diff_ff, diff_in;
   logic signed [2*VALUE_WIDTH+1:0] sq_full;
   logic [SQ_W-1:0]               sq_ff;
   logic [DIST_W-1:0]             acc_ff, acc_in;
   logic                          dist_valid_ff;
   logic [DIST_W-1:0]             best_dist_ff;
   logic [NIDX_W-1:0]             best_idx_ff;

   logic                  div_done;
   logic [NIDX_W-1:0]     quotient;
   logic [COLS_REG_W-1:0] remainder;
   logic                  rsp_valid_ff;
   nwvs_rsp_type          rsp_data_ff;

   assign wr_weight_ok = dp_cmd.wr_weight
                         && (32'(req_data.neuron_index) < MAX_NEURONS)
                         && (32'(req_data.dim_index) < MAX_DIMS);
   assign wr_point_ok  = dp_cmd.wr_point && (32'(req_data.dim_index) < MAX_DIMS);
   assign wr_addr = ADDR_W'(req_data.neuron_index) * DIM_STRIDE
                    + ADDR_W'(req_data.dim_index);
   assign rd_addr = ADDR_W'(mac_nidx) * DIM_STRIDE + ADDR_W'(mac_didx);

   always_ff @(posedge clock) begin
      if (wr_weight_ok) begin
         weight_mem[wr_addr] <= req_data.value;
      end
      w_rd_ff <= weight_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_point_ok) begin
         point_mem[DIDX_W'(req_data.dim_index)] <= req_data.value;
      end
      p_rd_ff <= point_mem[mac_didx];
   end

   assign diff_in = {w_rd_ff[VALUE_WIDTH-1], w_rd_ff} - {p_rd_ff[VALUE_WIDTH-1], p_rd_ff};
   assign sq_full = diff_ff * diff_ff;
   assign acc_in  = fd3_ff ? DIST_W'(sq_ff) : acc_ff + DIST_W'(sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         dist_valid_ff <= 1'b0;
         best_dist_ff  <= '0;
         best_idx_ff   <= '0;
      end else begin
         v1_ff         <= dp_cmd.mac_valid;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         dist_valid_ff <= v3_ff && ld3_ff;
         // strict less keeps the lowest index on ties
         if (dist_valid_ff && (fn4_ff || (acc_ff < best_dist_ff))) begin
            best_dist_ff <= acc_ff;
            best_idx_ff  <= ix4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      fd1_ff  <= dp_cmd.first_dim;
      ld1_ff  <= dp_cmd.last_dim;
      fn1_ff  <= dp_cmd.first_neuron;
      ix1_ff  <= mac_nidx;
      fd2_ff  <= fd1_ff;
      ld2_ff  <= ld1_ff;
      fn2_ff  <= fn1_ff;
      ix2_ff  <= ix1_ff;
      fd3_ff  <= fd2_ff;
      ld3_ff  <= ld2_ff;
      fn3_ff  <= fn2_ff;
      ix3_ff  <= ix2_ff;
      fn4_ff  <= fn3_ff;
      ix4_ff  <= ix3_ff;
      diff_ff <= diff_in;
      sq_ff   <= sq_full[SQ_W-1:0];
      if (v3_ff) begin
         acc_ff <= acc_in;
      end
   end

   nwvs_divider #(
      .DIVIDEND_W (NIDX_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (dp_cmd.div_start),
      .dividend  (best_idx_ff),
      .divisor   (cols_limit),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_done;
      end
   end

   always_ff @(posedge clock) begin
      if (div_done) begin
         rsp_data_ff.bmu_row <= OUT_W'(quotient) + OUT_W'(1);
         rsp_data_ff.bmu_col <= OUT_W'(remainder) + OUT_W'(1);
      end
   end

   assign dp_status.pipe_busy = v1_ff || v2_ff || v3_ff || dist_valid_ff;
   assign dp_status.div_done  = div_done;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;

endmodule

// File: hdl/nearest_weight_vector_search_unit.sv
// top level of the self-organizing-map best matching unit search
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ---------------------------
//   request   start, busy, req_data               taken when start && !busy
//   result    rsp_valid, rsp_data                 one-cycle strobe, no stall
//   config    csr_we, csr_index, csr_wdata        written when csr_we is high
//
// a weight load or a component without last is only stored; busy stays low
// a component with last runs the search: one multiply-accumulate per cycle
//   over every neuron and dimension in use, then the pipeline drains and the
//   index-to-row/column divider runs; rsp_valid pulses in the cycle after
//   the divider finishes
// busy is high from the search start until the divider finishes
// synchronous active-high reset clears control state and the best-so-far
// results cannot be held off; each search's result is shown for one cycle
module nearest_weight_vector_search_unit #(
   parameter int MAX_NEURONS = 1024,
   parameter int MAX_DIMS    = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  nwvs_pkg::nwvs_req_type           req_data,
   output logic                             rsp_valid,
   output nwvs_pkg::nwvs_rsp_type           rsp_data,
   input  logic                             csr_we,
   input  logic [nwvs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nwvs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import nwvs_pkg::*;
   `include "nearest_weight_vector_search_unit_defines.svh"

   // index and count widths follow the store sizes
   localparam int NIDX_W = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
   localparam int DIDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int NCNT_W = $clog2(MAX_NEURONS + 1);
   localparam int DCNT_W = $clog2(MAX_DIMS + 1);

   // configuration registers, raw as written
   logic [NCOUNT_REG_W-1:0] neuron_count_ff;
   logic [DCOUNT_REG_W-1:0] dimension_count_ff;
   logic [COLS_REG_W-1:0]   grid_columns_ff;

   // effective limits: zero acts as one, counts saturate at the store size
   logic [NCNT_W-1:0]     neuron_limit;
   logic [DCNT_W-1:0]     dim_limit;
   logic [COLS_REG_W-1:0] cols_limit;

   nwvs_cmd_type      dp_cmd;
   nwvs_status_type   dp_status;
   logic [NIDX_W-1:0] mac_nidx;
   logic [DIDX_W-1:0] mac_didx;

   always_ff @(posedge clock) begin
      if (reset) begin
         neuron_count_ff    <= NCOUNT_REG_W'(1);
         dimension_count_ff <= DCOUNT_REG_W'(1);
         grid_columns_ff    <= COLS_REG_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NEURON_COUNT:    neuron_count_ff    <= csr_wdata[NCOUNT_REG_W-1:0];
            CSR_DIMENSION_COUNT: dimension_count_ff <= csr_wdata[DCOUNT_REG_W-1:0];
            CSR_GRID_COLUMNS:    grid_columns_ff    <= csr_wdata[COLS_REG_W-1:0];
            default: begin
               // unused register index, write dropped
            end
         endcase
      end
   end

   always_comb begin
      if (neuron_count_ff == '0) begin
         neuron_limit = NCNT_W'(1);
      end else if (32'(neuron_count_ff) > MAX_NEURONS) begin
         neuron_limit = NCNT_W'(MAX_NEURONS);
      end else begin
         neuron_limit = NCNT_W'(neuron_count_ff);
      end
      if (dimension_count_ff == '0) begin
         dim_limit = DCNT_W'(1);
      end else if (32'(dimension_count_ff) > MAX_DIMS) begin
         dim_limit = DCNT_W'(MAX_DIMS);
      end else begin
         dim_limit = DCNT_W'(dimension_count_ff);
      end
      cols_limit = (grid_columns_ff == '0) ? COLS_REG_W'(1) : grid_columns_ff;
   end

   // sequencing of intake and sweep
   nwvs_ctrl #(
      .NIDX_W (NIDX_W),
      .DIDX_W (DIDX_W),
      .NCNT_W (NCNT_W),
      .DCNT_W (DCNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_data.cmd),
      .req_last     (req_data.last),
      .neuron_limit (neuron_limit),
      .dim_limit    (dim_limit),
      .dp_cmd       (dp_cmd),
      .mac_nidx     (mac_nidx),
      .mac_didx     (mac_didx),
      .dp_status    (dp_status)
   );

   // memories, distance pipeline, best tracking and divider
   nwvs_datapath #(
      .MAX_NEURONS (MAX_NEURONS),
      .MAX_DIMS    (MAX_DIMS),
      .NIDX_W      (NIDX_W),
      .DIDX_W      (DIDX_W)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .dp_cmd     (dp_cmd),
      .mac_nidx   (mac_nidx),
      .mac_didx   (mac_didx),
      .req_data   (req_data),
      .cols_limit (cols_limit),
      .dp_status  (dp_status),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   // a final component always launches a search
   `NWVS_ASSERT_NEXT(a_last_starts_search, clock, reset,
      start && !busy && (req_data.cmd == CMD_DATA_POINT) && req_data.last, busy,
      "final component did not start a search")

   // a result only follows a search
   `NWVS_ASSERT_NOW(a_rsp_after_search, clock, reset,
      rsp_valid, $past(busy), "result without a search")

   // no two results come back to back
   `NWVS_ASSERT_NEXT(a_rsp_single, clock, reset,
      rsp_valid, !rsp_valid, "result strobe longer than one cycle")

   // the sweep never overlaps the divider request
   `NWVS_ASSERT_NOW(a_sweep_excludes_div, clock, reset,
      dp_cmd.mac_valid, !dp_cmd.div_start, "divider started during sweep")

endmodule

// File: tb/sv/tb_nearest_weight_vector_search_unit.sv
// self-checking testbench of the self-organizing-map best matching unit search
`timescale 1ns / 1ps

module tb_nearest_weight_vector_search_unit;
   import nwvs_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int RESET_CYCLES  = 4;
   localparam int MAX_NEURONS   = 1024;
   localparam int MAX_DIMS      = 64;
   // room for pipeline drain, divider and output register, plus some slack
   localparam int SETTLE_CYCLES = 32;
   localparam int ITEM_TARGET   = 580;
   localparam int DRAIN_LIMIT   = 100000;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int REPORT_LIMIT  = 10;

   // register index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   nwvs_req_type           req_data;
   logic                   rsp_valid;
   nwvs_rsp_type           rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   nearest_weight_vector_search_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // one row of the directed table: a register write or an item
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] reg_idx;
      logic [CSR_DATA_W-1:0]  reg_val;
      nwvs_req_type           item;
      bit                     fixed;
      nwvs_rsp_type           fixed_rsp;
   } dir_row_type;

   // shadow of the block: weight store, point buffer, registers
   logic signed [VALUE_WIDTH-1:0] weight_mem [MAX_NEURONS][MAX_DIMS];
   bit                            weight_seen [MAX_NEURONS][MAX_DIMS];
   logic signed [VALUE_WIDTH-1:0] point_mem [MAX_DIMS];
   bit                            point_seen [MAX_DIMS];
   logic [NCOUNT_REG_W-1:0]       reg_neurons;
   logic [DCOUNT_REG_W-1:0]       reg_dims;
   logic [COLS_REG_W-1:0]         reg_cols;

   // best-match positions still owed by the block, oldest first
   nwvs_rsp_type bmu_expect [$];
   nwvs_rsp_type bmu_head;
   dir_row_type  directed_rows [$];

   int unsigned cycle_count;
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned random_items;
   int unsigned searches_issued;
   int unsigned results_seen;
   int unsigned phases_run;
   int unsigned quiet_from;
   bit          no_gap;

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  bmu_expect.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want,
                  got);
   endtask

   // result monitor: the block cannot be stalled, so every strobe is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (bmu_expect.size() == 0) begin
            note_mismatch("result with no search pending, row", 0, rsp_data.bmu_row);
         end else begin
            bmu_head = bmu_expect.pop_front();
            results_seen++;
            if (rsp_data.bmu_row !== bmu_head.bmu_row)
               note_mismatch("bmu_row", bmu_head.bmu_row, rsp_data.bmu_row);
            if (rsp_data.bmu_col !== bmu_head.bmu_col)
               note_mismatch("bmu_col", bmu_head.bmu_col, rsp_data.bmu_col);
         end
      end
   end

   // register values as the search sees them
   function automatic int unsigned neurons_in_use();
      if (reg_neurons == 0) return 1;
      if (reg_neurons > MAX_NEURONS) return MAX_NEURONS;
      return reg_neurons;
   endfunction

   function automatic int unsigned dims_in_use();
      if (reg_dims == 0) return 1;
      if (reg_dims > MAX_DIMS) return MAX_DIMS;
      return reg_dims;
   endfunction

   // exact sum of squared raw differences
   function automatic longint unsigned vector_distance(input int unsigned nrn,
                                                       input int unsigned dims);
      longint unsigned acc;
      longint          diff;
      acc = 0;
      for (int unsigned j = 0; j < dims; j++) begin
         diff = longint'(weight_mem[nrn][j]) - longint'(point_mem[j]);
         if (diff < 0) diff = -diff;
         acc += longint'(diff * diff);
      end
      return acc;
   endfunction

   // first strict minimum wins, so ties go to the lowest index
   function automatic int unsigned closest_neuron();
      longint unsigned best_sum;
      longint unsigned sum;
      int unsigned     best;
      int unsigned     dims;
      best     = 0;
      best_sum = 0;
      dims     = dims_in_use();
      for (int unsigned i = 0; i < neurons_in_use(); i++) begin
         sum = vector_distance(i, dims);
         if (i == 0 || sum < best_sum) begin
            best_sum = sum;
            best     = i;
         end
      end
      return best;
   endfunction

   // store an accepted item; a component with last also runs the search
   task automatic absorb_item(input nwvs_req_type it, output bit hit,
                              output nwvs_rsp_type rsp);
      int unsigned best;
      int unsigned cols;
      hit = 1'b0;
      rsp = '0;
      if (it.cmd == CMD_LOAD_WEIGHT) begin
         // last means nothing on a weight load
         weight_mem[it.neuron_index][it.dim_index]  = it.value;
         weight_seen[it.neuron_index][it.dim_index] = 1'b1;
      end else begin
         point_mem[it.dim_index]  = it.value;
         point_seen[it.dim_index] = 1'b1;
         if (it.last) begin
            best        = closest_neuron();
            cols        = (reg_cols == 0) ? 1 : reg_cols;
            rsp.bmu_row = OUT_W'(best / cols + 1);
            rsp.bmu_col = OUT_W'(best % cols + 1);
            hit         = 1'b1;
         end
      end
   endtask

   function automatic nwvs_req_type make_req(input logic cmd, input int unsigned nrn,
                                             input int unsigned dim,
                                             input logic signed [VALUE_WIDTH-1:0] v,
                                             input bit last);
      nwvs_req_type it;
      it.cmd          = cmd;
      it.neuron_index = NIDX_FIELD_W'(nrn);
      it.dim_index    = DIDX_FIELD_W'(dim);
      it.value        = v;
      it.last         = last;
      return it;
   endfunction

   // wide values, the extremes, and small ones that make ties likely
   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(3))
         0: return VALUE_WIDTH'($urandom);
         1: begin
            case ($urandom_range(3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return -16'sd1;
            endcase
         end
         default: return VALUE_WIDTH'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   // weight update mostly inside the searched range, sometimes anywhere
   function automatic nwvs_req_type random_weight(input int unsigned n, input int unsigned d);
      int unsigned nrn;
      int unsigned dim;
      nrn = ($urandom_range(2) == 0) ? $urandom_range(MAX_NEURONS - 1) : $urandom_range(n - 1);
      dim = ($urandom_range(3) == 0) ? $urandom_range(MAX_DIMS - 1) : $urandom_range(d - 1);
      return make_req(CMD_LOAD_WEIGHT, nrn, dim, pick_value(), 1'($urandom_range(1)));
   endfunction

   // present one item, hold it until taken, then predict what it causes
   task automatic send_item(input nwvs_req_type it, input bit fixed,
                            input nwvs_rsp_type fixed_rsp);
      bit           hit;
      nwvs_rsp_type rsp;
      // one long stretch of items with no idle cycles
      no_gap = (items_sent >= quiet_from && items_sent < quiet_from + 150);
      if (!no_gap) begin
         while ($urandom_range(99) < 36) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start    <= 1'b1;
      req_data <= it;
      // taken at the first edge with start high and busy low
      do @(posedge clock); while (busy !== 1'b0);
      items_sent++;
      absorb_item(it, hit, rsp);
      if (hit) begin
         searches_issued++;
         bmu_expect.push_back(fixed ? fixed_rsp : rsp);
      end
   endtask

   task automatic send_random(input nwvs_req_type it);
      random_items++;
      send_item(it, 1'b0, '0);
   endtask

   // wait until every search has reported and the block has settled
   task automatic wait_quiet();
      start <= 1'b0;
      while (bmu_expect.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_NEURON_COUNT:    reg_neurons = val;
         CSR_DIMENSION_COUNT: reg_dims    = val[DCOUNT_REG_W-1:0];
         CSR_GRID_COLUMNS:    reg_cols    = val;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // no search may read a weight or component that was never written
   task automatic fill_stores();
      int unsigned n;
      int unsigned d;
      n = neurons_in_use();
      d = dims_in_use();
      for (int unsigned i = 0; i < n; i++)
         for (int unsigned j = 0; j < d; j++)
            if (!weight_seen[i][j])
               send_item(make_req(CMD_LOAD_WEIGHT, i, j, pick_value(), 1'b0), 1'b0, '0);
      for (int unsigned j = 0; j < d; j++)
         if (!point_seen[j])
            send_item(make_req(CMD_DATA_POINT, $urandom_range(MAX_NEURONS - 1), j,
                               pick_value(), 1'b0), 1'b0, '0);
   endtask

   function automatic void put_csr(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      dir_row_type row;
      row         = '{default: '0};
      row.is_csr  = 1'b1;
      row.reg_idx = idx;
      row.reg_val = val;
      directed_rows.push_back(row);
   endfunction

   function automatic void put_item(input logic cmd, input int unsigned nrn,
                                    input int unsigned dim,
                                    input logic signed [VALUE_WIDTH-1:0] v, input bit last,
                                    input bit fixed, input int unsigned bmu_row,
                                    input int unsigned bmu_col);
      dir_row_type row;
      row                   = '{default: '0};
      row.item              = make_req(cmd, nrn, dim, v, last);
      row.fixed             = fixed;
      row.fixed_rsp.bmu_row = OUT_W'(bmu_row);
      row.fixed_rsp.bmu_col = OUT_W'(bmu_col);
      directed_rows.push_back(row);
   endfunction

   initial begin
      int unsigned phase_no;
      int unsigned target;
      int unsigned mark;
      int unsigned pick;
      int unsigned n;
      int unsigned d;
      int unsigned len;
      int unsigned dim;
      int unsigned waited;
      bit          downward;
      logic [CSR_DATA_W-1:0] cfg_n;
      logic [CSR_DATA_W-1:0] cfg_d;
      logic [CSR_DATA_W-1:0] cfg_c;

      // every input known from time zero, reset asserted at the start
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      reg_neurons = 1;
      reg_dims    = 1;
      reg_cols    = 1;
      no_gap      = 1'b0;
      quiet_from  = $urandom_range(150, 350);

      // directed table
      // reset settings: one neuron, one component, one column
      // last on a weight load is ignored, then max weight against min component
      put_item(CMD_LOAD_WEIGHT, 0, 0, 16'sh7FFF, 1'b1, 0, 0, 0);
      put_item(CMD_DATA_POINT, 1023, 0, 16'sh8000, 1'b1, 1, 1, 1);
      // 2 x 2 grid of 2-component weights; neurons 1 and 3 are equal
      put_csr(CSR_NEURON_COUNT, 4);
      put_csr(CSR_DIMENSION_COUNT, 2);
      put_csr(CSR_GRID_COLUMNS, 2);
      put_item(CMD_LOAD_WEIGHT, 0, 0, 16'sh0000, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 0, 1, 16'sh0000, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 1, 0, 16'sh0100, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 1, 1, 16'sh0100, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 2, 0, -16'sd256, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 2, 1, -16'sd256, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 3, 0, 16'sh0100, 1'b0, 0, 0, 0);
      put_item(CMD_LOAD_WEIGHT, 3, 1, 16'sh0100, 1'b0, 0, 0, 0);
      // highest neuron and component positions, outside the searched range
      put_item(CMD_LOAD_WEIGHT, 1023, 63, 16'sh7FFF, 1'b0, 0, 0, 0);
      // exact tie: the lower index wins
      put_item(CMD_DATA_POINT, 0, 0, 16'sh0100, 1'b0, 0, 0, 0);
      put_item(CMD_DATA_POINT, 0, 1, 16'sh0100, 1'b1, 1, 1, 2);
      put_item(CMD_DATA_POINT, 0, 0, -16'sd256, 1'b0, 0, 0, 0);
      put_item(CMD_DATA_POINT, 0, 1, -16'sd256, 1'b1, 0, 0, 0);
      // zero columns act as one column
      put_csr(CSR_GRID_COLUMNS, 0);
      put_item(CMD_DATA_POINT, 0, 0, -16'sd256, 1'b1, 1, 3, 1);
      // columns wider than the whole map
      put_csr(CSR_GRID_COLUMNS, 2047);
      put_item(CMD_DATA_POINT, 0, 1, -16'sd256, 1'b1, 1, 1, 3);
      // zero neurons act as one neuron
      put_csr(CSR_NEURON_COUNT, 0);
      put_item(CMD_DATA_POINT, 0, 0, -16'sd256, 1'b1, 1, 1, 1);
      // a write to the unused register index changes nothing
      put_csr(CSR_NEURON_COUNT, 4);
      put_csr(CSR_UNUSED_INDEX, 1);
      put_item(CMD_DATA_POINT, 0, 0, -16'sd256, 1'b1, 1, 1, 3);
      // zero components act as one component
      put_csr(CSR_DIMENSION_COUNT, 0);
      put_item(CMD_DATA_POINT, 0, 0, 16'sh0100, 1'b1, 1, 1, 2);
      // a component beyond the ones in use is stored but not searched
      put_item(CMD_DATA_POINT, 1023, 63, 16'sh7FFF, 1'b1, 0, 0, 0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_quiet();
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
         end else begin
            send_item(directed_rows[i].item, directed_rows[i].fixed,
                      directed_rows[i].fixed_rsp);
         end
      end

      // random part: one configuration per phase, the extremes first
      phase_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase_no)
            0: begin
               // columns wider than the map
               cfg_n = 40; cfg_d = 1; cfg_c = 1024;
            end
            1: begin
               // component counts above the maximum saturate
               cfg_n = 2; cfg_d = 127; cfg_c = 2;
            end
            default: begin
               cfg_n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 16);
               cfg_d = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
               // bits above the dimension register are dropped
               cfg_d = cfg_d | CSR_DATA_W'($urandom_range(15) << DCOUNT_REG_W);
               cfg_c = ($urandom_range(9) == 0) ? 1024 : $urandom_range(0, 18);
            end
         endcase
         wait_quiet();
         write_reg(CSR_NEURON_COUNT, cfg_n);
         write_reg(CSR_DIMENSION_COUNT, cfg_d);
         write_reg(CSR_GRID_COLUMNS, cfg_c);
         fill_stores();
         phases_run++;
         n      = neurons_in_use();
         d      = dims_in_use();
         target = (phase_no < 2) ? 3 : $urandom_range(4, 10);
         mark   = searches_issued;

         while (searches_issued - mark < target && items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
               // well-formed point, components in either order, last on the final one
               downward = 1'($urandom_range(1));
               for (int unsigned k = 0; k < d; k++) begin
                  if ($urandom_range(9) == 0) send_random(random_weight(n, d));
                  dim = downward ? d - 1 - k : k;
                  send_random(make_req(CMD_DATA_POINT, $urandom_range(MAX_NEURONS - 1), dim,
                                       pick_value(), k == d - 1));
               end
            end else if (pick < 72) begin
               send_random(random_weight(n, d));
            end else if (pick < 84) begin
               // search again on the buffered point after one changed component
               dim = $urandom_range(1) ? $urandom_range(d - 1) : $urandom_range(MAX_DIMS - 1);
               send_random(make_req(CMD_DATA_POINT, $urandom_range(MAX_NEURONS - 1), dim,
                                    pick_value(), 1'b1));
            end else if (pick < 95) begin
               // broken point: some components and no last
               len = $urandom_range(1, d);
               repeat (len)
                  send_random(make_req(CMD_DATA_POINT, $urandom_range(MAX_NEURONS - 1),
                                       $urandom_range(MAX_DIMS - 1), pick_value(), 1'b0));
            end else begin
               send_random(make_req(CMD_LOAD_WEIGHT, $urandom_range(MAX_NEURONS - 1),
                                    $urandom_range(MAX_DIMS - 1), pick_value(), 1'b1));
            end
         end
         phase_no++;
      end

      // drain, then settle
      start <= 1'b0;
      waited = 0;
      while (bmu_expect.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (bmu_expect.size() != 0)
         note_mismatch("searches never reported, count", 0, bmu_expect.size());

      $display("%0d items sent (%0d random) across %0d map configurations", items_sent,
               random_items, phases_run);
      $display("%0d searches predicted, %0d positions checked, %0d mismatches",
               searches_issued, results_seen, mismatches);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
